>>> rtl/assert_macros.svh
// Assertion macros for the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in this cycle, consequent in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent holds in this cycle, consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bpa_pkg.sv
// Shared types, codes and helper functions of the buddy page allocator.
package bpa_pkg;

  localparam int CNT_W = 11;
  localparam int OFF_W = 10;
  localparam int LOG_W = 4;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [CNT_W-1:0] RESET_POOL_PAGES = 11'd1024;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;

  // Register 0 sits at byte address 0; bit 2 selects the register word.
  localparam logic REG_POOL_PAGES = 1'b0;

  typedef struct packed {
    logic             req_type;
    logic [CNT_W-1:0] page_count;
    logic [OFF_W-1:0] page_offset;
  } req_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] block_offset;
    logic [CNT_W-1:0] largest_free;
  } rsp_word_t;

  // Exponent of the smallest power of two not below n; zero and one give 0.
  function automatic logic [LOG_W-1:0] ceil_log2_cnt(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] m;
    logic [LOG_W-1:0] r;
    m = n - 11'd1;
    r = '0;
    if (n > 11'd1) begin
      for (int b = 0; b < CNT_W; b++) begin
        if (m[b]) begin
          r = LOG_W'(b + 1);
        end
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/buddy_page_allocator_top.sv
// Binary buddy page allocator: each request word allocates or frees a
// power-of-two block of pages and returns one response word with a status,
// the block offset and the largest free block left. One request is in work
// at a time. An allocation walks the tree down and back up, a free walks it
// up only, over the L tree levels between the pool and the requested block
// size (up to 10 for a 1024-page pool); a rejected request skips both walks.
// Both walks use the node memory, with one write port and one registered
// read port: the downward walk reads one child per level with a registered
// read, the upward walk reads one sibling and writes one parent per cycle.
// After reset and after each write of pool_pages the tree is rebuilt by a
// sweep of its 2*P-1 nodes (P the rounded pool size); no request is taken.
`include "assert_macros.svh"

module buddy_page_allocator_top import bpa_pkg::*; #(
  parameter int PAGE_LIMIT = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_word_t         req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_word_t         rsp
);

  logic [CNT_W-1:0] pool_pages;
  logic             cfg_we;
  logic             res_valid, res_ready;
  rsp_word_t        res;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_PAGES);
  assign prdata = (paddr[2] == REG_POOL_PAGES) ? DATA_W'(pool_pages) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_pages <= RESET_POOL_PAGES;
    end else if (cfg_we) begin
      pool_pages <= pwdata[CNT_W-1:0];
    end
  end

  bpa_core #(.PAGE_LIMIT(PAGE_LIMIT)) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_pages (pwdata[CNT_W-1:0]),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The response register lets the core finish while the last word waits.
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
      if (res_valid) begin
        rsp <= res;
      end
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready,
               "request taken while the previous one is still in work")
  `ASSERT_NEXT(a_rebuild_after_cfg, cfg_we, !req_ready,
               "request taken while the tree is being rebuilt")
  `ASSERT_SAME(a_fail_offset_zero, rsp_valid && (rsp.status != ST_OK),
               rsp.block_offset == '0, "failed request carries a nonzero offset")

endmodule

>>> rtl/bpa_tree_mem.sv
// Node memory of the allocation tree: one write port, one registered read port.
module bpa_tree_mem #(
  parameter int AW = 11,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [VW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [VW-1:0] rdata
);

  logic [VW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bpa_core.sv
// Sequencer that walks the tree down and up through the single node memory.
module bpa_core import bpa_pkg::*; #(
  parameter int PAGE_LIMIT = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_pages,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_word_t        req,
  output logic             res_valid,
  input  logic             res_ready,
  output rsp_word_t        res
);

  localparam int MAX_EFF = (PAGE_LIMIT < 2048) ? PAGE_LIMIT : 2048;
  localparam int LVL = $clog2(MAX_EFF + 1) - 1;
  localparam int AW = LVL + 1;
  localparam int VW = LVL + 1;
  localparam logic [LOG_W-1:0] LVL_K = LOG_W'(LVL);
  localparam logic [LOG_W-1:0] RESET_RAW = ceil_log2_cnt(RESET_POOL_PAGES);
  localparam logic [LOG_W-1:0] RESET_K = (RESET_RAW > LVL_K) ? LVL_K : RESET_RAW;

  typedef enum logic [2:0] {
    S_SWEEP, S_IDLE, S_DOWN_RD, S_DOWN_EV, S_MARK, S_UP, S_DONE
  } state_t;

  state_t           state;
  logic [LOG_W-1:0] kp, k, ks;
  logic [AW-1:0]    idx, sidx;
  logic [VW:0]      sval;
  logic [LVL-1:0]   off;
  logic [VW-1:0]    cur, root;
  logic [1:0]       status;
  logic             is_free;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [VW-1:0]    mem_wdata, mem_rdata;

  logic [VW-1:0]    psz, size;
  logic [LOG_W-1:0] in_ks, cfg_raw, cfg_k;
  logic [11:0]      in_size12;
  logic             alloc_fail, free_fail;
  logic [AW-1:0]    free_idx, idx2p1, idx2p2, par;
  logic [VW:0]      up_size, up_sum;
  logic [VW-1:0]    up_max, up_val;
  logic [AW:0]      sidx_w;
  logic             sw_hit, sweep_last;
  logic [VW:0]      sw_val;

  bpa_tree_mem #(.AW(AW), .VW(VW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  function automatic logic [AW-1:0] sibling(input logic [AW-1:0] n);
    return n[0] ? n + AW'(1) : n - AW'(1);
  endfunction

  always_comb begin
    psz        = VW'(1) << kp;
    size       = VW'(1) << ks;
    in_ks      = ceil_log2_cnt(req.page_count);
    in_size12  = 12'(1) << in_ks;
    alloc_fail = (in_ks > kp) || (12'(root) < in_size12);
    free_fail  = (12'(req.page_offset) >= 12'(psz)) || (in_ks > kp);
    free_idx   = AW'(req.page_offset >> in_ks) + (AW'(1) << (kp - in_ks)) - AW'(1);
    cfg_raw    = ceil_log2_cnt(cfg_pages);
    cfg_k      = (cfg_raw > LVL_K) ? LVL_K : cfg_raw;

    idx2p1     = AW'({idx, 1'b1});
    idx2p2     = idx2p1 + AW'(1);
    par        = (idx - AW'(1)) >> 1;

    // On a free walk, a parent whose two children are wholly free merges into one block.
    up_size    = (VW+1)'(1) << (k + LOG_W'(1));
    up_sum     = (VW+1)'(cur) + (VW+1)'(mem_rdata);
    up_max     = (cur > mem_rdata) ? cur : mem_rdata;
    up_val     = (is_free && (up_sum == up_size)) ? VW'(up_size) : up_max;

    // Node value halves each time the sweep index starts a new level.
    sidx_w     = (AW+1)'(sidx);
    sw_hit     = ((sidx_w + (AW+1)'(1)) & sidx_w) == '0;
    sw_val     = sw_hit ? (sval >> 1) : sval;
    sweep_last = sidx == AW'({psz, 1'b0} - (VW+1)'(2));
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '0;
    mem_raddr = idx2p1;
    case (state)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sidx;
        mem_wdata = VW'(sw_val);
      end
      S_DOWN_RD: begin
        mem_raddr = idx2p1;
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = is_free ? size : '0;
        mem_raddr = sibling(idx);
      end
      S_UP: begin
        mem_we    = 1'b1;
        mem_waddr = par;
        mem_wdata = up_val;
        mem_raddr = sibling(par);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      kp    <= RESET_K;
      sidx  <= '0;
      sval  <= (VW+1)'(1) << (RESET_K + LOG_W'(1));
    end else begin
      if (mem_we && (mem_waddr == '0)) begin
        root <= mem_wdata;
      end
      case (state)
        S_SWEEP: begin
          sidx <= sidx + AW'(1);
          sval <= sw_val;
          if (sweep_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            is_free <= (req.req_type == REQ_FREE);
            ks      <= in_ks;
            off     <= '0;
            status  <= ST_OK;
            idx     <= '0;
            k       <= kp;
            if (req.req_type == REQ_FREE) begin
              if (free_fail) begin
                status <= ST_OUTSIDE;
                state  <= S_DONE;
              end else begin
                idx   <= free_idx;
                k     <= in_ks;
                state <= S_MARK;
              end
            end else if (alloc_fail) begin
              status <= ST_NO_SPACE;
              state  <= S_DONE;
            end else if (in_ks == kp) begin
              state <= S_MARK;
            end else begin
              state <= S_DOWN_RD;
            end
          end
        end
        S_DOWN_RD: begin
          state <= S_DOWN_EV;
        end
        S_DOWN_EV: begin
          // Prefer the left child; going right moves the offset by half a node.
          if (mem_rdata >= size) begin
            idx <= idx2p1;
          end else begin
            idx <= idx2p2;
            off <= off + (LVL'(1) << (k - LOG_W'(1)));
          end
          k     <= k - LOG_W'(1);
          state <= ((k - LOG_W'(1)) == ks) ? S_MARK : S_DOWN_RD;
        end
        S_MARK: begin
          cur   <= mem_wdata;
          state <= (idx == '0) ? S_DONE : S_UP;
        end
        S_UP: begin
          cur <= up_val;
          idx <= par;
          k   <= k + LOG_W'(1);
          if (par == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_we) begin
        kp    <= cfg_k;
        sidx  <= '0;
        sval  <= (VW+1)'(1) << (cfg_k + LOG_W'(1));
        state <= S_SWEEP;
      end
    end
  end

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res = '{status: status, block_offset: OFF_W'(off), largest_free: CNT_W'(root)};

endmodule
